FILE: rtl/sjrs_pkg.sv
// Shared types and codes for the stepper jog and retract sequencer.
package sjrs_pkg;

	// Width of the configuration index and data on the write port.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	// Width of the speed and step fields on the result stream.
	localparam int unsigned OUT_VALUE_W = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_OPERATING_MODE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PRESET_VALUE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FIXED_SPEED    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_JOG_STEPS      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTERN_SPEED   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_EXTERN_STEPS   = 3'd5;

	typedef enum logic [1:0] {
		ACT_BUTTON     = 2'd0,
		ACT_TICK       = 2'd1,
		ACT_MODE_RESET = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		MODE_SINGLE = 2'd0,
		MODE_REPEAT = 2'd1,
		MODE_MANUAL = 2'd2,
		MODE_EXTERN = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		BTN_SELECT = 2'd0,
		BTN_UP     = 2'd1,
		BTN_DOWN   = 2'd2,
		BTN_OTHER  = 2'd3
	} button_t;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_CW   = 2'd1,
		CMD_CCW  = 2'd2,
		CMD_STOP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REQ_NONE = 2'd0,
		REQ_CW   = 2'd1,
		REQ_CCW  = 2'd2
	} req_t;

	// One input transaction; the layout below the action matches s_tdata.
	typedef struct packed {
		action_t    action;
		logic [1:0] extern_request;
		logic       motor_dir_ccw;
		logic       motor_running;
		logic       button_pressed;
		button_t    button_code;
	} item_t;

	// One result transaction, in the bit order of m_tdata.
	typedef struct packed {
		logic                   clear_extern_request;
		logic [OUT_VALUE_W-1:0] move_steps;
		logic [OUT_VALUE_W-1:0] move_speed;
		cmd_t                   move_command;
	} result_t;

endpackage

FILE: rtl/sjrs_in_reg.sv
// Input register stage holding one accepted transaction.
module sjrs_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sjrs_pkg::item_t in_item,
	output logic           valid_s1,
	output sjrs_pkg::item_t item_s1,
	input  logic           advance
);

	logic valid_q_s1;

	// The stage takes a new item when empty or when its item moves on.
	assign in_ready = !valid_q_s1 || advance;
	assign valid_s1 = valid_q_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_q_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: rtl/sjrs_core.sv
// Configuration registers, sequencer state and the per-item result logic.
module sjrs_core #(
	parameter int unsigned VALUE_WIDTH   = 16,
	parameter int unsigned RETRACT_SHIFT = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [sjrs_pkg::CFG_INDEX_W-1:0]   wr_index,
	input  logic [sjrs_pkg::CFG_DATA_W-1:0]    wr_data,
	input  logic                               fire,
	input  sjrs_pkg::item_t                    item,
	output sjrs_pkg::result_t                  result
);

	// Stored values never exceed the 16-bit register width.
	localparam int unsigned VW = (VALUE_WIDTH < sjrs_pkg::CFG_DATA_W) ?
		VALUE_WIDTH : sjrs_pkg::CFG_DATA_W;
	localparam int unsigned OW = sjrs_pkg::OUT_VALUE_W;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_CW      = 3'd1,
		ST_CCW     = 3'd2,
		ST_RUN     = 3'd3,
		ST_RETRACT = 3'd4
	} seq_state_t;

	sjrs_pkg::mode_t   mode_q;
	logic [VW-1:0]     preset_q;
	logic [VW-1:0]     fixed_speed_q;
	logic [VW-1:0]     jog_steps_q;
	logic [VW-1:0]     extern_speed_q;
	logic [VW-1:0]     extern_steps_q;

	seq_state_t        state_q, state_d;
	logic              held_valid_q, held_valid_d;
	sjrs_pkg::button_t held_code_q, held_code_d;
	logic              held_pressed_q, held_pressed_d;
	logic [1:0]        last_dir_q, last_dir_d;

	logic [OW-1:0] preset_w, fixed_speed_w, jog_steps_w, extern_speed_w, extern_steps_w;
	logic [OW-1:0] preset_retract_w, jog_retract_w;
	logic          sel_down, sel_up, up_down, up_up, dn_down, dn_up;
	sjrs_pkg::cmd_t retract_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= sjrs_pkg::MODE_SINGLE;
			preset_q       <= '0;
			fixed_speed_q  <= '0;
			jog_steps_q    <= '0;
			extern_speed_q <= '0;
			extern_steps_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				sjrs_pkg::REG_OPERATING_MODE: mode_q <= sjrs_pkg::mode_t'(wr_data[1:0]);
				sjrs_pkg::REG_PRESET_VALUE:   preset_q <= wr_data[VW-1:0];
				sjrs_pkg::REG_FIXED_SPEED:    fixed_speed_q <= wr_data[VW-1:0];
				sjrs_pkg::REG_JOG_STEPS:      jog_steps_q <= wr_data[VW-1:0];
				sjrs_pkg::REG_EXTERN_SPEED:   extern_speed_q <= wr_data[VW-1:0];
				sjrs_pkg::REG_EXTERN_STEPS:   extern_steps_q <= wr_data[VW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign preset_w         = OW'(preset_q);
	assign fixed_speed_w    = OW'(fixed_speed_q);
	assign jog_steps_w      = OW'(jog_steps_q);
	assign extern_speed_w   = OW'(extern_speed_q);
	assign extern_steps_w   = OW'(extern_steps_q);
	assign preset_retract_w = OW'(preset_q >> RETRACT_SHIFT);
	assign jog_retract_w    = OW'(jog_steps_q >> RETRACT_SHIFT);

	// Matches against the stored button event; a consumed event matches nothing.
	assign sel_down = held_valid_q && held_code_q == sjrs_pkg::BTN_SELECT && held_pressed_q;
	assign sel_up   = held_valid_q && held_code_q == sjrs_pkg::BTN_SELECT && !held_pressed_q;
	assign up_down  = held_valid_q && held_code_q == sjrs_pkg::BTN_UP && held_pressed_q;
	assign up_up    = held_valid_q && held_code_q == sjrs_pkg::BTN_UP && !held_pressed_q;
	assign dn_down  = held_valid_q && held_code_q == sjrs_pkg::BTN_DOWN && held_pressed_q;
	assign dn_up    = held_valid_q && held_code_q == sjrs_pkg::BTN_DOWN && !held_pressed_q;

	// A retract runs opposite to the direction of the last move.
	assign retract_cmd = item.motor_dir_ccw ? sjrs_pkg::CMD_CW : sjrs_pkg::CMD_CCW;

	always_comb begin
		result         = '0;
		state_d        = state_q;
		held_valid_d   = held_valid_q;
		held_code_d    = held_code_q;
		held_pressed_d = held_pressed_q;
		last_dir_d     = last_dir_q;
		unique case (item.action)
			sjrs_pkg::ACT_BUTTON: begin
				held_valid_d   = 1'b1;
				held_code_d    = item.button_code;
				held_pressed_d = item.button_pressed;
			end
			sjrs_pkg::ACT_TICK: begin
				case (mode_q) inside
					sjrs_pkg::MODE_SINGLE, sjrs_pkg::MODE_REPEAT: begin
						unique case (state_q)
							ST_IDLE: begin
								if (sel_down) begin
									result.move_command = sjrs_pkg::CMD_CW;
									result.move_speed   = fixed_speed_w;
									result.move_steps   = preset_w;
									held_valid_d        = 1'b0;
									state_d             = ST_CW;
								end
							end
							ST_CW, ST_CCW: begin
								if (sel_up) begin
									held_valid_d = 1'b0;
									state_d      = ST_RUN;
								end else if (mode_q == sjrs_pkg::MODE_REPEAT &&
									!item.motor_running) begin
									result.move_command = sjrs_pkg::CMD_CW;
									result.move_speed   = fixed_speed_w;
									result.move_steps   = preset_w;
								end
							end
							ST_RUN: begin
								if (!item.motor_running) begin
									result.move_command = retract_cmd;
									result.move_speed   = fixed_speed_w;
									result.move_steps   = preset_retract_w;
									state_d             = ST_RETRACT;
								end
							end
							ST_RETRACT: begin
								if (!item.motor_running) begin
									state_d = ST_IDLE;
								end
							end
							default: state_d = ST_IDLE;
						endcase
					end
					sjrs_pkg::MODE_MANUAL: begin
						unique case (state_q)
							ST_IDLE: begin
								if (up_down) begin
									result.move_command = sjrs_pkg::CMD_CW;
									result.move_speed   = preset_w;
									result.move_steps   = jog_steps_w;
									held_valid_d        = 1'b0;
									state_d             = ST_CW;
								end else if (dn_down) begin
									result.move_command = sjrs_pkg::CMD_CCW;
									result.move_speed   = preset_w;
									result.move_steps   = jog_steps_w;
									held_valid_d        = 1'b0;
									state_d             = ST_CCW;
								end
							end
							ST_CW: begin
								if (up_up) begin
									held_valid_d = 1'b0;
									state_d      = ST_RUN;
								end else if (!item.motor_running) begin
									result.move_command = sjrs_pkg::CMD_CW;
									result.move_speed   = preset_w;
									result.move_steps   = jog_steps_w;
								end
							end
							ST_CCW: begin
								if (dn_up) begin
									held_valid_d = 1'b0;
									state_d      = ST_RUN;
								end else if (!item.motor_running) begin
									result.move_command = sjrs_pkg::CMD_CCW;
									result.move_speed   = preset_w;
									result.move_steps   = jog_steps_w;
								end
							end
							ST_RUN: begin
								// Manual jogs retract at once, without waiting for the motor.
								result.move_command = retract_cmd;
								result.move_speed   = preset_w;
								result.move_steps   = jog_retract_w;
								state_d             = ST_RETRACT;
							end
							ST_RETRACT: begin
								if (!item.motor_running) begin
									state_d = ST_IDLE;
								end
							end
							default: state_d = ST_IDLE;
						endcase
					end
					default: begin
						if (item.extern_request != last_dir_q) begin
							last_dir_d = item.extern_request;
							if (item.extern_request == sjrs_pkg::REQ_CCW) begin
								result.move_command = sjrs_pkg::CMD_CCW;
								result.move_speed   = extern_speed_w;
								result.move_steps   = extern_steps_w;
							end else if (item.extern_request == sjrs_pkg::REQ_CW) begin
								result.move_command = sjrs_pkg::CMD_CW;
								result.move_speed   = extern_speed_w;
								result.move_steps   = extern_steps_w;
							end else if (item.extern_request == sjrs_pkg::REQ_NONE) begin
								result.move_command = sjrs_pkg::CMD_STOP;
							end
						end
						result.clear_extern_request = !item.motor_running &&
							item.extern_request != sjrs_pkg::REQ_NONE;
					end
				endcase
			end
			sjrs_pkg::ACT_MODE_RESET: begin
				state_d             = ST_IDLE;
				result.move_command = sjrs_pkg::CMD_STOP;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			held_valid_q   <= 1'b0;
			held_code_q    <= sjrs_pkg::BTN_SELECT;
			held_pressed_q <= 1'b0;
			last_dir_q     <= sjrs_pkg::REQ_NONE;
		end else if (fire) begin
			state_q        <= state_d;
			held_valid_q   <= held_valid_d;
			held_code_q    <= held_code_d;
			held_pressed_q <= held_pressed_d;
			last_dir_q     <= last_dir_d;
		end
	end

`ifndef SYNTHESIS
	a_consume_clears_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.action == sjrs_pkg::ACT_TICK && mode_q != sjrs_pkg::MODE_EXTERN &&
		state_q == ST_IDLE && state_d != ST_IDLE |=> !held_valid_q)
		else $error("starting a move did not consume the held button");
	a_clear_only_extern: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.clear_extern_request |-> mode_q == sjrs_pkg::MODE_EXTERN)
		else $error("clear flag raised outside external mode");
	a_mode_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.action == sjrs_pkg::ACT_MODE_RESET |=> state_q == ST_IDLE)
		else $error("mode change reset did not return to idle");
`endif

endmodule

FILE: rtl/sjrs_out_reg.sv
// Result register that holds a finished transaction until it is taken.
module sjrs_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sjrs_pkg::result_t result,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_ready,
	output sjrs_pkg::result_t out_result
);

	logic valid_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			out_result <= result;
		end
	end

endmodule

FILE: rtl/stepper_jog_retract_sequencer_unit.sv
// Top level of the stepper jog and retract sequencer.
//
//   port group       | direction | carries
//   s_t*             | in        | button events, run ticks and mode change resets
//   m_t*             | out       | one move command per input transaction
//   wr_*             | in        | configuration register writes
//
// Every input transaction yields exactly one result, registered first in the input
// register and then in the result register. One transaction per cycle is sustained
// while m_tready is high; the sequencer state is the only loop.
// A stalled m_tready holds the result and, once the input register is also full,
// drops s_tready. Reset clears the sequencer, held button, config and valid flags.
module stepper_jog_retract_sequencer_unit #(
	parameter int unsigned VALUE_WIDTH   = 16,
	parameter int unsigned RETRACT_SHIFT = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,  // button_code, button_pressed,
	                                                   // motor_running, motor_dir_ccw,
	                                                   // extern_request, zero pad
	input  logic [1:0]                       s_tuser,  // action
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [39:0]                      m_tdata,  // move_command, move_speed,
	                                                   // move_steps, clear_extern_request,
	                                                   // zero pad
	input  logic                             wr_en,
	input  logic [sjrs_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [sjrs_pkg::CFG_DATA_W-1:0]  wr_data
);

	sjrs_pkg::item_t   in_item;
	sjrs_pkg::item_t   item_s1;
	sjrs_pkg::result_t result;
	sjrs_pkg::result_t out_result;
	logic              valid_s1;
	logic              can_load;
	logic              advance;

	assign in_item = {sjrs_pkg::action_t'(s_tuser), s_tdata[6:0]};
	assign advance = valid_s1 && can_load;
	assign m_tdata = {5'b0, out_result};

	sjrs_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance)
	);

	sjrs_core #(
		.VALUE_WIDTH   (VALUE_WIDTH),
		.RETRACT_SHIFT (RETRACT_SHIFT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.fire     (advance),
		.item     (item_s1),
		.result   (result)
	);

	sjrs_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (valid_s1),
		.result     (result),
		.can_load   (can_load),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

`ifndef SYNTHESIS
	a_ready_only_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && m_tvalid && !m_tready)
		else $error("input stalled without a blocked result");
	a_advance_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("advanced item produced no result");
	a_stop_has_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_result.move_command == sjrs_pkg::CMD_STOP |->
		out_result.move_speed == '0 && out_result.move_steps == '0)
		else $error("stop command carries speed or steps");
`endif

endmodule
